[rtl/core/homogeneous_vertex_transform_core_assert.svh]
// Assertion macros shared by the vertex transform core.
// Needs no package; each macro takes its clock and active-low reset.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_ASSERT_SVH

// Condition in the same cycle.
`define HVT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform assertion failed");

// Condition in the following cycle.
`define HVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform assertion failed");

`endif

[rtl/core/hvt_pkg.sv]
// Shared types and constants of the vertex transform core.
// No dependencies.
package hvt_pkg;

    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int SLOT_W     = 16;
    localparam int NUM_REGS   = 4;
    localparam int ACC_W      = COORD_W + 6;
    localparam int QUO_W      = COORD_W + 1;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_LSB    = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef acc_t [3:0]                acc_vec_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_word_t;
    typedef cfg_word_t [NUM_REGS-1:0]  cfg_bank_t;

    typedef enum logic [1:0] {
        REG_FROM_X = 2'd0,
        REG_FROM_Y = 2'd1,
        REG_FROM_Z = 2'd2,
        REG_OFFSET = 2'd3
    } reg_idx_t;

    typedef struct packed {
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
    } vertex_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   w_zero;
        logic   saturated;
    } result_t;

endpackage

[rtl/core/hvt_cfg.sv]
// Matrix register bank behind the APB-style configuration port.
// Depends on hvt_pkg.
module hvt_cfg import hvt_pkg::*; #(
    parameter int COEFF_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_bank_t             coeffs
);

    localparam int KF = COEFF_WIDTH - 4;

    cfg_bank_t regs_reg;
    cfg_bank_t regs_next;
    reg_idx_t  idx;

    // Unity coefficient placed in the given slot.
    function automatic cfg_word_t unity(input reg_idx_t slot);
        return CFG_DATA_W'(1) << (SLOT_W * int'(slot) + KF);
    endfunction

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:REG_LSB]);
    assign pready = 1'b1;
    assign prdata = regs_reg[idx];
    assign coeffs = regs_reg;

    always_comb begin
        regs_next = regs_reg;
        if (psel && penable && pwrite) begin
            regs_next[idx] = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_FROM_X] <= unity(REG_FROM_X);
            regs_reg[REG_FROM_Y] <= unity(REG_FROM_Y);
            regs_reg[REG_FROM_Z] <= unity(REG_FROM_Z);
            regs_reg[REG_OFFSET] <= unity(REG_OFFSET);
        end else begin
            regs_reg <= regs_next;
        end
    end

endmodule

[rtl/core/hvt_mac.sv]
// Matrix multiply: a product stage, then a sum stage with the offset row.
// Depends on hvt_pkg.
module hvt_mac import hvt_pkg::*; #(
    parameter int COEFF_WIDTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  vertex_t   in_vtx,
    input  cfg_bank_t coeffs,
    output logic      out_valid,
    output acc_vec_t  acc
);

    localparam int KF     = COEFF_WIDTH - 4;
    localparam int OFS_SH = COORD_FRAC - KF;
    localparam int PROD_W = COORD_W + COEFF_WIDTH;

    logic signed [COEFF_WIDTH-1:0] coef [4][4];
    coord_t                        vin  [3];
    logic signed [PROD_W-1:0]      prod_reg  [3][4];
    logic signed [PROD_W-1:0]      prod_next [3][4];
    acc_t                          acc_reg  [4];
    acc_t                          acc_next [4];
    logic [1:0]                    v_reg;

    assign vin[0] = in_vtx.in_x;
    assign vin[1] = in_vtx.in_y;
    assign vin[2] = in_vtx.in_z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                coef[i][j] = $signed(coeffs[i][SLOT_W*j +: COEFF_WIDTH]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod_next[i][j] = vin[i] * coef[i][j];
            end
        end
        // Products round toward minus infinity; the offset row is exact.
        for (int j = 0; j < 4; j++) begin
            acc_next[j] = ACC_W'(coef[3][j]) <<< OFS_SH;
            for (int i = 0; i < 3; i++) begin
                acc_next[j] = acc_next[j] + ACC_W'(prod_reg[i][j] >>> KF);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    assign out_valid = v_reg[1];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            acc[j] = acc_reg[j];
        end
    end

endmodule

[rtl/core/hvt_div.sv]
// Perspective divide: sign and range prep, one restoring quotient bit per
// stage for x, y and z in parallel, then saturation. Depends on hvt_pkg.
`include "homogeneous_vertex_transform_core_assert.svh"
module hvt_div import hvt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  acc_vec_t acc,
    output logic     out_valid,
    output result_t  res
);

    localparam int SH    = COORD_W - COORD_FRAC + 1;
    localparam int DVD_W = ACC_W + COORD_FRAC;
    localparam int LAST  = QUO_W + 1;

    typedef struct packed {
        logic [ACC_W-1:0] num_mag;
        logic [ACC_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        logic [ACC_W-1:0] den;
        logic             wz;
        coord_t [2:0]     clamp;
        logic             clamp_sat;
    } side_t;

    lane_t   lane_reg  [QUO_W+1][3];
    lane_t   lane_next [QUO_W+1][3];
    side_t   side_reg  [QUO_W+1];
    side_t   side_next [QUO_W+1];
    result_t res_reg;
    result_t res_next;
    logic [LAST:0] v_reg;

    always_comb begin
        logic signed [ACC_W-1:0] wv;
        logic signed [ACC_W-1:0] nv;
        logic [ACC_W-1:0]        nmag;
        logic [DVD_W-1:0]        dvd;
        logic [ACC_W:0]          trial;
        logic                    nbit;
        logic [QUO_W-1:0]        lim;
        logic [QUO_W-1:0]        mag;
        logic [QUO_W-1:0]        sval;
        logic                    lsat;
        logic                    any_sat;
        coord_t                  outv [3];

        // Prep stage.
        wv = acc[3];
        side_next[0].wz        = (wv == '0);
        side_next[0].den       = wv[ACC_W-1] ? ACC_W'(-wv) : ACC_W'(wv);
        side_next[0].clamp_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            nv   = acc[l];
            nmag = nv[ACC_W-1] ? ACC_W'(-nv) : ACC_W'(nv);
            lane_next[0][l].num_mag = nmag;
            lane_next[0][l].neg     = nv[ACC_W-1] ^ wv[ACC_W-1];
            // Quotient would need more than QUO_W bits.
            lane_next[0][l].ovf = {{SH{1'b0}}, nmag} >= {side_next[0].den, {SH{1'b0}}};
            lane_next[0][l].rem = nmag >> SH;
            lane_next[0][l].quo = '0;
            if (nv[ACC_W-1:COORD_W-1] == '0 || nv[ACC_W-1:COORD_W-1] == '1) begin
                side_next[0].clamp[l] = nv[COORD_W-1:0];
            end else begin
                side_next[0].clamp_sat = 1'b1;
                side_next[0].clamp[l]  = nv[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                     : {1'b0, {(COORD_W-1){1'b1}}};
            end
        end

        // Quotient bit stages, most significant bit first.
        for (int k = 1; k <= QUO_W; k++) begin
            side_next[k] = side_reg[k-1];
            for (int l = 0; l < 3; l++) begin
                lane_next[k][l] = lane_reg[k-1][l];
                dvd   = {lane_reg[k-1][l].num_mag, {COORD_FRAC{1'b0}}};
                nbit  = dvd[QUO_W-k];
                trial = {lane_reg[k-1][l].rem, nbit} - {1'b0, side_reg[k-1].den};
                if (!trial[ACC_W]) begin
                    lane_next[k][l].rem = trial[ACC_W-1:0];
                    lane_next[k][l].quo = {lane_reg[k-1][l].quo[QUO_W-2:0], 1'b1};
                end else begin
                    lane_next[k][l].rem = {lane_reg[k-1][l].rem[ACC_W-2:0], nbit};
                    lane_next[k][l].quo = {lane_reg[k-1][l].quo[QUO_W-2:0], 1'b0};
                end
            end
        end

        // Saturation and sign.
        any_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            lim = lane_reg[QUO_W][l].neg ? (QUO_W'(1) << (COORD_W-1))
                                         : ((QUO_W'(1) << (COORD_W-1)) - QUO_W'(1));
            lsat = lane_reg[QUO_W][l].ovf || (lane_reg[QUO_W][l].quo > lim);
            mag  = lsat ? lim : lane_reg[QUO_W][l].quo;
            sval = lane_reg[QUO_W][l].neg ? (-mag) : mag;
            if (side_reg[QUO_W].wz) begin
                outv[l] = side_reg[QUO_W].clamp[l];
            end else begin
                outv[l] = sval[COORD_W-1:0];
                any_sat = any_sat | lsat;
            end
        end
        res_next.out_x     = outv[0];
        res_next.out_y     = outv[1];
        res_next.out_z     = outv[2];
        res_next.w_zero    = side_reg[QUO_W].wz;
        res_next.saturated = side_reg[QUO_W].wz ? side_reg[QUO_W].clamp_sat : any_sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QUO_W; k++) begin
                side_reg[k] <= side_next[k];
                for (int l = 0; l < 3; l++) begin
                    lane_reg[k][l] <= lane_next[k][l];
                end
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    assign out_valid = v_reg[LAST];
    assign res       = res_reg;

    // The partial remainder stays below the divisor unless the lane overflowed.
    `HVT_ASSERT_SAME(a_rem_below_den, aclk, aresetn,
        v_reg[1] && !side_reg[1].wz && !lane_reg[1][0].ovf,
        lane_reg[1][0].rem < side_reg[1].den)
    `HVT_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, !en, $stable(v_reg))
    `HVT_ASSERT_NEXT(a_valid_advances, aclk, aresetn, en && v_reg[0], v_reg[1])

endmodule

[rtl/core/hvt_ostage.sv]
// Output register with a one-beat skid buffer; drives the pipeline enable.
// Depends on hvt_pkg.
module hvt_ostage import hvt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_res,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_data,
    output logic    en
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    push;
    logic    out_take;

    assign en       = !skid_valid_reg;
    assign push     = en && in_valid;
    assign out_take = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (out_take) begin
            out_valid_next = push;
            if (push) begin
                out_next = in_res;
            end
        end else if (push) begin
            // Output is stalled: park the beat leaving the pipeline.
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/core/homogeneous_vertex_transform_core.sv]
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
// Depends on hvt_pkg, hvt_cfg, hvt_mac, hvt_div and hvt_ostage.
//
// The core takes one vertex beat per clock while s_ready is high and returns
// one result beat per vertex, in order. Each vertex passes through two
// multiply-accumulate stages, a prep stage, the divider, which resolves one
// quotient bit per pipeline stage (33 stages), a saturation stage and the
// output register. A one-beat skid buffer lets the core keep accepting while
// a finished result waits; s_ready drops only once that buffer is full.
// Matrix registers come up as the identity and should be written only while
// no vertex is in flight.
module homogeneous_vertex_transform_core import hvt_pkg::*; #(
    parameter int COEFF_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vertex_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_bank_t coeffs;
    acc_vec_t  acc;
    result_t   div_res;
    logic      en;
    logic      mac_valid;
    logic      div_valid;

    assign s_ready = en;

    hvt_cfg #(.COEFF_WIDTH(COEFF_WIDTH)) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeffs  (coeffs)
    );

    hvt_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_vtx    (s_data),
        .coeffs    (coeffs),
        .out_valid (mac_valid),
        .acc       (acc)
    );

    hvt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mac_valid),
        .acc       (acc),
        .out_valid (div_valid),
        .res       (div_res)
    );

    hvt_ostage u_ostage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_res   (div_res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .en       (en)
    );

endmodule
